// ----- design/bpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpu_pkg
// shared types and constants for the bitmap pixel unpacker
// ----------------------------------------------------------------------------
package bpu_pkg;

  // palette store
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int COLOR_W     = 24;

  // image dimensions and row layout
  localparam int DIM_W = 16;                 // width / height / column
  localparam int WB_W  = DIM_W + 5;          // width * 24 bits
  localparam int RBC_W = WB_W - 3;           // bytes per padded row

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  // bits per pixel codes
  typedef enum logic [1:0] {
    DEPTH_1  = 2'd0,
    DEPTH_4  = 2'd1,
    DEPTH_8  = 2'd2,
    DEPTH_24 = 2'd3
  } depth_t;

  // input item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

endpackage

// ----- design/bmp_pixel_unpack.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_unpack
// unpacks bitmap pixel array bytes into blue-green-red pixels, at 1, 4 and 8 bits via a palette
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in_     | input     | in_valid / in_ready    | mode, data byte, palette entry
//  out_    | output    | out_valid / out_ready  | bgr, column, row/image/byte flags
//  cfg_    | input     | cfg_we (no wait)       | index, write data
//
// a palette load, a 24-bit byte, an 8-bit byte and a pad byte each give at
// most one pixel; a 4-bit byte gives up to 2 pixels and a 1-bit up to 8,
// one pixel per cycle while the output is not stalled, bounded by the single
// palette read port. palette data lives in a synchronous ram; valid bits in
// flops are cleared by reset, so no clearing pass is needed.
// a stalled output holds the pixel in the output stage and halts unpacking;
// the next byte is taken in the cycle the current one finishes.
//
module bmp_pixel_unpack (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [7:0]                      in_data_byte,
  input  logic [7:0]                      in_palette_index,
  input  logic [7:0]                      in_palette_blue,
  input  logic [7:0]                      in_palette_green,
  input  logic [7:0]                      in_palette_red,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_pixel_blue,
  output logic [7:0]                      out_pixel_green,
  output logic [7:0]                      out_pixel_red,
  output logic [bpu_pkg::DIM_W-1:0]       out_pixel_column,
  output logic                            out_row_end,
  output logic                            out_image_end,
  output logic                            out_last_of_byte
);

  localparam int DIM_W   = bpu_pkg::DIM_W;
  localparam int WB_W    = bpu_pkg::WB_W;
  localparam int RBC_W   = bpu_pkg::RBC_W;
  localparam int PAL_AW  = bpu_pkg::PAL_AW;
  localparam int COLOR_W = bpu_pkg::COLOR_W;

  // ---------------------------------------------------------------- config
  bpu_pkg::depth_t    depth_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= bpu_pkg::DEPTH_24;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bpu_pkg::CFG_DEPTH_MODE:   depth_r  <= bpu_pkg::depth_t'(cfg_wdata[1:0]);
        bpu_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        bpu_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero dimensions count as one
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  assign eff_w = (width_r  == '0) ? DIM_W'(1) : width_r;
  assign eff_h = (height_r == '0) ? DIM_W'(1) : height_r;

  // row layout: bits per row, data bytes and padded bytes
  logic [WB_W-1:0]  row_bits;
  logic [RBC_W-1:0] data_bytes;
  logic [RBC_W-1:0] row_bytes;
  logic [WB_W-1:0]  row_bits_b;
  logic [WB_W-1:0]  row_bits_w;

  always_comb begin
    case (depth_r)
      bpu_pkg::DEPTH_1: row_bits = WB_W'(eff_w);
      bpu_pkg::DEPTH_4: row_bits = WB_W'(eff_w) << 2;
      bpu_pkg::DEPTH_8: row_bits = WB_W'(eff_w) << 3;
      default:          row_bits = (WB_W'(eff_w) << 4) + (WB_W'(eff_w) << 3);
    endcase
  end

  assign row_bits_b = row_bits + WB_W'(7);
  assign row_bits_w = row_bits + WB_W'(31);
  assign data_bytes = row_bits_b[WB_W-1:3];
  assign row_bytes  = {row_bits_w[WB_W-1:5], 2'b00};

  // ---------------------------------------------------------------- state
  logic [DIM_W-1:0]   col_r,     col_nxt;
  logic [RBC_W-1:0]   rbc_r,     rbc_nxt;
  logic [DIM_W-1:0]   row_r,     row_nxt;
  logic [15:0]        partial_r, partial_nxt;
  logic [1:0]         phase_r,   phase_nxt;

  // unpack stage: holds the byte or load being worked on
  logic               u_valid_r, u_valid_nxt;
  logic               u_mode_r;
  logic [7:0]         u_byte_r;
  logic [7:0]         u_pidx_r;
  logic [COLOR_W-1:0] u_pcolor_r;
  logic [2:0]         u_pos_r,   u_pos_nxt;

  // output stage
  logic               b_valid_r, b_valid_nxt;
  logic               b_pal_r;
  logic [COLOR_W-1:0] b_color_r;
  logic [DIM_W-1:0]   b_col_r;
  logic               b_re_r;
  logic               b_ie_r;
  logic               b_lob_r;

  // palette ram and its valid bits
  logic [COLOR_W-1:0] pal_mem [bpu_pkg::PAL_ENTRIES];
  logic [bpu_pkg::PAL_ENTRIES-1:0] pal_vld_r;
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_vld_r;

  // ---------------------------------------------------------------- step
  logic               is24;
  logic               active;
  logic               col_ok;
  logic               emit;
  logic               done;
  logic               advance;
  logic               step_fire;
  logic               in_fire;
  logic               re;
  logic               ie;
  logic [2:0]         last_pos;
  logic [PAL_AW-1:0]  pix_idx;
  logic [DIM_W:0]     col_inc;
  logic [DIM_W:0]     row_inc;
  logic [RBC_W:0]     rbc_inc;
  logic               wr_en;
  logic               rd_en;

  assign is24    = (depth_r == bpu_pkg::DEPTH_24);
  assign active  = (rbc_r < data_bytes);
  assign col_ok  = (col_r < eff_w);
  assign col_inc = {1'b0, col_r} + (DIM_W+1)'(1);
  assign row_inc = {1'b0, row_r} + (DIM_W+1)'(1);
  assign rbc_inc = {1'b0, rbc_r} + (RBC_W+1)'(1);
  assign re      = (col_inc >= {1'b0, eff_w});
  assign ie      = re && (row_inc >= {1'b0, eff_h});

  // position of the last pixel inside a byte
  always_comb begin
    case (depth_r)
      bpu_pkg::DEPTH_1: last_pos = 3'd7;
      bpu_pkg::DEPTH_4: last_pos = 3'd1;
      default:          last_pos = 3'd0;
    endcase
  end

  // pixel index, high bits first
  always_comb begin
    case (depth_r)
      bpu_pkg::DEPTH_1: pix_idx = PAL_AW'(u_byte_r[3'd7 - u_pos_r]);
      bpu_pkg::DEPTH_4: pix_idx = PAL_AW'(u_pos_r[0] ? u_byte_r[3:0] : u_byte_r[7:4]);
      default:          pix_idx = PAL_AW'(u_byte_r);
    endcase
  end

  always_comb begin
    emit = 1'b0;
    done = 1'b1;
    if (u_valid_r && u_mode_r == bpu_pkg::MODE_PIXEL && active) begin
      if (is24) begin
        // third byte of a pixel completes it
        emit = (phase_r >= 2'd2) && col_ok;
      end else begin
        emit = col_ok;
        done = !col_ok || (u_pos_r == last_pos) || re;
      end
    end
  end

  // output stage frees when empty or being drained
  assign advance   = !b_valid_r || out_ready;
  assign step_fire = u_valid_r && (!emit || advance);
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !u_valid_r || (step_fire && done);

  assign wr_en = step_fire && (u_mode_r == bpu_pkg::MODE_LOAD);
  assign rd_en = step_fire && emit && !is24;

  // ---------------------------------------------------------------- next state
  always_comb begin
    col_nxt     = col_r;
    rbc_nxt     = rbc_r;
    row_nxt     = row_r;
    partial_nxt = partial_r;
    phase_nxt   = phase_r;
    u_pos_nxt   = u_pos_r;
    u_valid_nxt = u_valid_r;

    if (step_fire && u_mode_r == bpu_pkg::MODE_PIXEL) begin
      u_pos_nxt = u_pos_r + 3'd1;

      if (emit) begin
        col_nxt = col_inc[DIM_W-1:0];
        if (re) begin
          row_nxt = ie ? '0 : row_inc[DIM_W-1:0];
        end
      end

      // 24-bit color gathering
      if (is24 && active) begin
        if (phase_r >= 2'd2) begin
          phase_nxt   = 2'd0;
          partial_nxt = '0;
        end else begin
          if (phase_r[0]) begin
            partial_nxt = {u_byte_r, partial_r[7:0]};
          end else begin
            partial_nxt = {partial_r[15:8], u_byte_r};
          end
          phase_nxt = phase_r + 2'd1;
        end
      end

      // byte finished: count it and close the padded row
      if (done) begin
        rbc_nxt = rbc_inc[RBC_W-1:0];
        if (rbc_inc >= {1'b0, row_bytes}) begin
          rbc_nxt     = '0;
          col_nxt     = '0;
          phase_nxt   = 2'd0;
          partial_nxt = '0;
        end
      end
    end

    if (step_fire && done) begin
      u_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      u_valid_nxt = 1'b1;
      u_pos_nxt   = 3'd0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (step_fire && emit) begin
      b_valid_nxt = 1'b1;
    end else if (out_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      rbc_r     <= '0;
      row_r     <= '0;
      partial_r <= '0;
      phase_r   <= 2'd0;
      u_valid_r <= 1'b0;
      u_pos_r   <= 3'd0;
      b_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      rbc_r     <= rbc_nxt;
      row_r     <= row_nxt;
      partial_r <= partial_nxt;
      phase_r   <= phase_nxt;
      u_valid_r <= u_valid_nxt;
      u_pos_r   <= u_pos_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      u_mode_r   <= in_mode;
      u_byte_r   <= in_data_byte;
      u_pidx_r   <= in_palette_index;
      u_pcolor_r <= {in_palette_red, in_palette_green, in_palette_blue};
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (step_fire && emit) begin
      b_pal_r   <= !is24;
      b_color_r <= {u_byte_r, partial_r};
      b_col_r   <= col_r;
      b_re_r    <= re;
      b_ie_r    <= ie;
      b_lob_r   <= done;
    end
  end

  // palette valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (wr_en) begin
      pal_vld_r[u_pidx_r[PAL_AW-1:0]] <= 1'b1;
    end
  end

  // palette ram: loads and reads share the one step slot, so a read always
  // sees every earlier load without forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[u_pidx_r[PAL_AW-1:0]] <= u_pcolor_r;
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[pix_idx];
      rd_vld_r  <= pal_vld_r[pix_idx];
    end
  end

  // ---------------------------------------------------------------- outputs
  logic [COLOR_W-1:0] out_color;
  assign out_color = b_pal_r ? (rd_vld_r ? rd_data_r : '0) : b_color_r;

  assign out_valid        = b_valid_r;
  assign out_pixel_blue   = out_color[7:0];
  assign out_pixel_green  = out_color[15:8];
  assign out_pixel_red    = out_color[23:16];
  assign out_pixel_column = b_col_r;
  assign out_row_end      = b_re_r;
  assign out_image_end    = b_ie_r;
  assign out_last_of_byte = b_lob_r;

endmodule
